// File: rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// Intel HEX record parser package
// Status codes, record type codes and the word that passes from the
// character decoder to the result stage.
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_EOF          = 4'd1,
    ST_SEGMENT      = 4'd2,
    ST_LINEAR       = 4'd3,
    ST_START_LINEAR = 4'd4,
    ST_NO_COLON     = 4'd5,
    ST_SHORT        = 4'd6,
    ST_BAD_DIGIT    = 4'd7,
    ST_CHECKSUM     = 4'd8,
    ST_UNSUPPORTED  = 4'd9
  } status_e;

  localparam logic [7:0] COLON_CHAR   = 8'h3A;
  localparam logic [7:0] KIND_DATA    = 8'h00;
  localparam logic [7:0] KIND_EOF     = 8'h01;
  localparam logic [7:0] KIND_SEGMENT = 8'h02;
  localparam logic [7:0] KIND_LINEAR  = 8'h04;
  localparam logic [7:0] KIND_START   = 8'h05;

  localparam logic [9:0] POS_MAX      = 10'd1023;
  // Length, two offset bytes, type and checksum: five bytes, ten digits.
  localparam logic [9:0] HEADER_DIGITS = 10'd10;
  // Index of the first data byte in the record.
  localparam logic [9:0] DATA_START   = 10'd4;

  // Word from the decoder to the result stage.
  typedef struct packed {
    logic        is_status;
    logic [7:0]  data;
    logic [16:0] rel_addr;   // record offset plus data index
    status_e     code;
    logic [15:0] base_val;   // first two data bytes, for base records
  } event_t;

  // Bit 4 set marks a character that is not a hex digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h10;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b0, ch[3:0]};
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      r = {1'b0, 4'(ch[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

// File: rtl/ihex_front.sv
// ----------------------------------------------------------------------------
// Intel HEX character decoder
// Decodes one character per cycle while accept_i is high, keeps the per-line state and issues a
// data word or an end-of-line status word.
// ----------------------------------------------------------------------------
module ihex_front import ihex_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] character_i,
  input  logic       line_end_i,
  output logic       push_o,
  output event_t     event_o
);

  logic [9:0] pos_q, pos_d;
  logic [3:0] high_nib_q, high_nib_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] len_q, len_d;
  logic [15:0] offset_q, offset_d;
  logic [7:0] kind_q, kind_d;
  logic [15:0] ftd_q, ftd_d;
  status_e err_q, err_d;

  logic [9:0] d, need, data_end, need_end;
  logic [8:0] b;
  logic [4:0] nib;
  logic [7:0] byte_val, idx;
  logic in_data, emit_data;
  status_e code;

  always_comb begin
    pos_d      = pos_q;
    high_nib_d = high_nib_q;
    sum_d      = sum_q;
    len_d      = len_q;
    offset_d   = offset_q;
    kind_d     = kind_q;
    ftd_d      = ftd_q;
    err_d      = err_q;
    emit_data  = 1'b0;

    d        = pos_q - 10'd1;
    b        = d[9:1];
    need     = {1'b0, len_q, 1'b0} + HEADER_DIGITS;
    data_end = {2'b0, len_q} + DATA_START;
    nib      = nibble_of(character_i);
    byte_val = {high_nib_q, nib[3:0]};
    idx      = 8'(b - 9'd4);
    in_data  = ({1'b0, b} >= DATA_START) && ({1'b0, b} < data_end);

    if (pos_q == 10'd0) begin
      if (character_i != COLON_CHAR) begin
        err_d = ST_NO_COLON;
      end
    end else if (err_q == ST_OK && d < need) begin
      if (nib[4]) begin
        err_d = ST_BAD_DIGIT;
      end else if (!d[0]) begin
        high_nib_d = nib[3:0];
      end else begin
        sum_d = sum_q + byte_val;
        if (b == 9'd0) begin
          len_d = byte_val;
        end else if (b == 9'd1) begin
          offset_d = {byte_val, offset_q[7:0]};
        end else if (b == 9'd2) begin
          offset_d = {offset_q[15:8], byte_val};
        end else if (b == 9'd3) begin
          kind_d = byte_val;
        end else if (in_data) begin
          if (idx == 8'd0) begin
            ftd_d = {byte_val, ftd_q[7:0]};
          end else if (idx == 8'd1) begin
            ftd_d = {ftd_q[15:8], byte_val};
          end
          emit_data = (kind_q == KIND_DATA) && !line_end_i;
        end
      end
    end

    // Status uses the state as updated by this last character.
    need_end = {1'b0, len_d, 1'b0} + HEADER_DIGITS;
    if (err_d != ST_OK) begin
      code = err_d;
    end else if (pos_q < need_end) begin
      code = ST_SHORT;
    end else if (sum_d != 8'd0) begin
      code = ST_CHECKSUM;
    end else begin
      unique case (kind_d)
        KIND_DATA:    code = ST_OK;
        KIND_EOF:     code = ST_EOF;
        KIND_SEGMENT: code = ST_SEGMENT;
        KIND_LINEAR:  code = ST_LINEAR;
        KIND_START:   code = ST_START_LINEAR;
        default:      code = ST_UNSUPPORTED;
      endcase
    end

    event_o.is_status = line_end_i;
    event_o.data      = line_end_i ? 8'd0 : byte_val;
    event_o.rel_addr  = line_end_i ? 17'd0 : ({1'b0, offset_q} + {9'd0, idx});
    event_o.code      = line_end_i ? code : ST_OK;
    event_o.base_val  = ftd_d;
    push_o            = accept_i && (line_end_i || emit_data);

    if (line_end_i) begin
      pos_d      = 10'd0;
      high_nib_d = 4'd0;
      sum_d      = 8'd0;
      len_d      = 8'd0;
      offset_d   = 16'd0;
      kind_d     = 8'd0;
      ftd_d      = 16'd0;
      err_d      = ST_OK;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 10'd0;
      high_nib_q <= 4'd0;
      sum_q      <= 8'd0;
      len_q      <= 8'd0;
      offset_q   <= 16'd0;
      kind_q     <= 8'd0;
      ftd_q      <= 16'd0;
      err_q      <= ST_OK;
    end else if (accept_i) begin
      pos_q      <= pos_d;
      high_nib_q <= high_nib_d;
      sum_q      <= sum_d;
      len_q      <= len_d;
      offset_q   <= offset_d;
      kind_q     <= kind_d;
      ftd_q      <= ftd_d;
      err_q      <= err_d;
    end
  end

endmodule

// File: rtl/ihex_queue.sv
// ----------------------------------------------------------------------------
// Intel HEX word queue
// Small register queue between the decoder and the result stage.
// ----------------------------------------------------------------------------
module ihex_queue import ihex_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output event_t rdata_o,
  output logic   empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  event_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// File: rtl/ihex_back.sv
// ----------------------------------------------------------------------------
// Intel HEX result stage
// Owns the upper address base, resolves absolute byte addresses and holds
// the result word until it is popped.
// ----------------------------------------------------------------------------
module ihex_back import ihex_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  event_t      event_i,
  input  logic        avail_i,
  output logic        take_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic        is_status_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] byte_address_o,
  output logic [3:0]  status_code_o
);

  logic        valid_q;
  logic [31:0] base_q, base_d;
  logic        is_status_q;
  logic [7:0]  data_q;
  logic [31:0] addr_q;
  status_e     code_q;

  assign take_o = avail_i && (!valid_q || pop_i);

  always_comb begin
    base_d = base_q;
    if (event_i.is_status) begin
      case (event_i.code)
        ST_EOF:     base_d = 32'd0;
        ST_SEGMENT: base_d = {12'd0, event_i.base_val, 4'd0};
        ST_LINEAR:  base_d = {event_i.base_val, 16'd0};
        default:    base_d = base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      base_q  <= 32'd0;
    end else begin
      if (take_o) begin
        valid_q <= 1'b1;
        base_q  <= base_d;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Data words see the base as left by every earlier status word.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      is_status_q <= event_i.is_status;
      data_q      <= event_i.data;
      addr_q      <= event_i.is_status ? 32'd0 : (base_q + {15'd0, event_i.rel_addr});
      code_q      <= event_i.code;
    end
  end

  assign empty_o        = !valid_q;
  assign is_status_o    = is_status_q;
  assign data_byte_o    = data_q;
  assign byte_address_o = addr_q;
  assign status_code_o  = code_q;

endmodule

// File: rtl/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Decodes Intel HEX lines character by character into data bytes and
// end-of-line status words.
// ----------------------------------------------------------------------------
// The parser takes one character per clock and never stalls on its own: full
// rises only when QUEUE_DEPTH words wait in the internal queue and the output
// register holds one more. A data word of a type 00 record is issued for each
// completed data byte, and one status word follows the character flagged as
// line end. The decoder writes a word into the queue at the edge that accepts
// its character, and the output register takes it once the words ahead of it
// have left and the register is empty or being popped. Data words are
// provisional: commit them only when the status of their line is
// "data ok". The upper address base lives in the result stage and changes in
// word order, so addresses always use the base of earlier records.
module intel_hex_record_parser import ihex_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  character_i,
  input  logic        line_end_i,
  output logic        empty,
  input  logic        pop,
  output logic        is_status_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] byte_address_o,
  output logic [3:0]  status_code_o
);

  logic   accept;
  logic   fr_push;
  event_t fr_event;
  event_t q_event;
  logic   q_empty;
  logic   bk_take;

  assign accept = push && !full;

  ihex_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .character_i (character_i),
    .line_end_i  (line_end_i),
    .push_o      (fr_push),
    .event_o     (fr_event)
  );

  ihex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .wdata_i (fr_event),
    .full_o  (full),
    .pop_i   (bk_take),
    .rdata_o (q_event),
    .empty_o (q_empty)
  );

  ihex_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .event_i        (q_event),
    .avail_i        (!q_empty),
    .take_o         (bk_take),
    .pop_i          (pop),
    .empty_o        (empty),
    .is_status_o    (is_status_o),
    .data_byte_o    (data_byte_o),
    .byte_address_o (byte_address_o),
    .status_code_o  (status_code_o)
  );

  a_data_code_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !is_status_o) |-> (status_code_o == ST_OK))
    else $error("data word carries a nonzero status code");

  a_status_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_status_o) |-> (data_byte_o == 8'd0 && byte_address_o == 32'd0))
    else $error("status word carries data or address bits");

  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_code_o <= ST_UNSUPPORTED))
    else $error("status code out of range");

  a_no_lost_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_push) |-> !full)
    else $error("decoder issued a word into a full queue");

endmodule
